>>> hw/rtl/drs_pkg.sv
package drs_pkg;

  localparam int DefQueueDepth = 16;
  localparam int TrackW        = 16;
  localparam int TagW          = 16;
  localparam int EntryW        = TrackW + TagW;
  localparam int SDataW        = 48;
  localparam int MDataW        = 40;

  localparam logic [2:0] POL_FIFO  = 3'd0;
  localparam logic [2:0] POL_SSTF  = 3'd1;
  localparam logic [2:0] POL_LOOK  = 3'd2;
  localparam logic [2:0] POL_CLOOK = 3'd3;
  localparam logic [2:0] POL_FLOOK = 3'd4;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SEL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SEL,
    ST_SCAN,
    ST_SHIFT,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    SM_FIRST,
    SM_ABS,
    SM_UP,
    SM_DOWN
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t          mode;
    logic [TrackW-1:0]   track;
    logic [TrackW-1:0]   head;
    logic                found;
    logic [TrackW-1:0]   best_d;
  } cmp_req_t;

  typedef struct packed {
    logic                take;
    logic [TrackW-1:0]   span;
  } cmp_rsp_t;

endpackage

>>> hw/rtl/disk_request_scheduler_unit.sv
// Add: the accepted beat passes through the add state to the output state.
// Select on N queued entries: each scan pass goes through the shared compare unit and queue
// RAM port, a second pass follows when LOOK or C-LOOK finds nothing ahead, and then the
// entries behind the taken entry k move down to close the gap.
// One item is in work at a time; a finished result waits in the output register.
// Reset clears the counts and policy (fifo) and sets the sweep upward; queue RAM is not cleared.
module disk_request_scheduler_unit
  import drs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DefQueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic [2:0]        cfg_wdata,  // policy
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [SDataW-1:0] s_tdata,    // req_track, req_tag, head_track
  input  logic [0:0]        s_tuser,    // cmd
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [MDataW-1:0] m_tdata,    // out_track, out_tag, sweeping_up, zero fill
  output logic [1:0]        m_tuser     // granted, dropped
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH) + 1;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [EntryW-1:0] mem_rdata;
  cmp_req_t          cmp_req;
  cmp_rsp_t          cmp_rsp;

  drs_seq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .cmp_req   (cmp_req),
    .cmp_rsp   (cmp_rsp)
  );

  drs_ram #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  drs_cmp u_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

endmodule

>>> hw/rtl/drs_ram.sv
module drs_ram
  import drs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [$clog2(QUEUE_DEPTH)+1-1:0]      waddr,
  input  logic [EntryW-1:0]                     wdata,
  input  logic [$clog2(QUEUE_DEPTH)+1-1:0]      raddr,
  output logic [EntryW-1:0]                     rdata
);

  localparam int ADDR_W = $clog2(QUEUE_DEPTH) + 1;

  // Two banks: the active queue and the pending queue, picked by the bank bit.
  logic [EntryW-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/drs_cmp.sv
module drs_cmp
  import drs_pkg::*;
(
  input  cmp_req_t req,
  output cmp_rsp_t rsp
);

  logic [TrackW:0]   diff;
  logic              below;
  logic [TrackW-1:0] up_d;
  logic [TrackW-1:0] down_d;
  logic              ok;
  logic [TrackW-1:0] d;

  assign diff   = {1'b0, req.track} - {1'b0, req.head};
  assign below  = diff[TrackW];
  assign up_d   = diff[TrackW-1:0];
  assign down_d = req.head - req.track;

  always_comb begin
    ok = 1'b1;
    d  = '0;
    case (req.mode)
      SM_FIRST: begin
        ok = 1'b1;
        d  = '0;
      end
      SM_ABS: begin
        ok = 1'b1;
        d  = below ? down_d : up_d;
      end
      SM_UP: begin
        ok = !below;
        d  = up_d;
      end
      SM_DOWN: begin
        // A request on the head track counts as lying in both directions.
        ok = below || (up_d == '0);
        d  = down_d;
      end
      default: begin
        ok = 1'b0;
        d  = '0;
      end
    endcase
  end

  // Strict compare keeps the oldest entry on a tie.
  assign rsp.take = ok && (!req.found || (d < req.best_d));
  assign rsp.span = d;

endmodule

>>> hw/rtl/drs_seq.sv
module drs_seq
  import drs_pkg::*;
#(
  parameter int QUEUE_DEPTH = DefQueueDepth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wen,
  input  logic [2:0]                        cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [SDataW-1:0]                 s_tdata,
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [MDataW-1:0]                 m_tdata,
  output logic [1:0]                        m_tuser,
  output logic                              mem_we,
  output logic [$clog2(QUEUE_DEPTH)+1-1:0]  mem_waddr,
  output logic [EntryW-1:0]                 mem_wdata,
  output logic [$clog2(QUEUE_DEPTH)+1-1:0]  mem_raddr,
  input  logic [EntryW-1:0]                 mem_rdata,
  output cmp_req_t                          cmp_req,
  input  cmp_rsp_t                          cmp_rsp
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t state, state_next;

  logic [2:0]        policy, policy_next;
  logic [TrackW-1:0] trk_q, trk_q_next;
  logic [TagW-1:0]   tag_q, tag_q_next;
  logic [TrackW-1:0] head_q, head_q_next;

  logic              sel_bank, sel_bank_next;
  logic [CNT_W-1:0]  act_cnt, act_cnt_next;
  logic [CNT_W-1:0]  pen_cnt, pen_cnt_next;
  logic              sweep_dir, sweep_dir_next;

  logic [CNT_W-1:0]  iss, iss_next;
  logic [CNT_W-1:0]  scan_len, scan_len_next;
  logic              cmp_vld, cmp_vld_next;
  logic [IDX_W-1:0]  cmp_idx, cmp_idx_next;
  logic              pass2, pass2_next;
  scan_mode_t        mode, mode_next;
  logic [TrackW-1:0] scan_head, scan_head_next;

  logic              found, found_next;
  logic [TrackW-1:0] best_d, best_d_next;
  logic [IDX_W-1:0]  best_idx, best_idx_next;
  logic [TrackW-1:0] best_trk, best_trk_next;
  logic [TagW-1:0]   best_tag, best_tag_next;

  logic              res_granted, res_granted_next;
  logic              res_dropped, res_dropped_next;
  logic [TrackW-1:0] res_trk, res_trk_next;
  logic [TagW-1:0]   res_tag, res_tag_next;

  logic              out_vld, out_vld_next;
  logic [MDataW-1:0] out_data, out_data_next;
  logic [1:0]        out_user, out_user_next;

  logic              do_swap;
  logic [CNT_W-1:0]  eff_cnt;
  logic              is_look;
  logic              scan_done;
  logic              shift_done;
  logic              retry;
  logic              out_free;

  assign is_look    = (policy == POL_LOOK) || (policy == POL_FLOOK);
  assign do_swap    = (policy == POL_FLOOK) && (act_cnt == '0) && (pen_cnt != '0);
  assign eff_cnt    = do_swap ? pen_cnt : act_cnt;
  assign scan_done  = (iss == scan_len) && !cmp_vld;
  assign shift_done = (iss == act_cnt) && !cmp_vld;
  assign retry      = !found && !pass2 && (is_look || (policy == POL_CLOOK));
  assign out_free   = !out_vld || m_tready;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_vld;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

  assign cmp_req.mode   = mode;
  assign cmp_req.track  = mem_rdata[TrackW-1:0];
  assign cmp_req.head   = scan_head;
  assign cmp_req.found  = found;
  assign cmp_req.best_d = best_d;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser[0] == CMD_ADD) ? ST_ADD : ST_SEL;
        end
      end
      ST_ADD: begin
        state_next = ST_OUT;
      end
      ST_SEL: begin
        state_next = (eff_cnt == '0) ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = retry ? ST_SCAN : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (shift_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    policy_next      = cfg_wen ? cfg_wdata : policy;
    trk_q_next       = trk_q;
    tag_q_next       = tag_q;
    head_q_next      = head_q;
    sel_bank_next    = sel_bank;
    act_cnt_next     = act_cnt;
    pen_cnt_next     = pen_cnt;
    sweep_dir_next   = sweep_dir;
    iss_next         = iss;
    scan_len_next    = scan_len;
    cmp_vld_next     = 1'b0;
    cmp_idx_next     = cmp_idx;
    pass2_next       = pass2;
    mode_next        = mode;
    scan_head_next   = scan_head;
    found_next       = found;
    best_d_next      = best_d;
    best_idx_next    = best_idx;
    best_trk_next    = best_trk;
    best_tag_next    = best_tag;
    res_granted_next = res_granted;
    res_dropped_next = res_dropped;
    res_trk_next     = res_trk;
    res_tag_next     = res_tag;
    out_vld_next     = out_vld && !m_tready;
    out_data_next    = out_data;
    out_user_next    = out_user;
    mem_we           = 1'b0;
    mem_waddr        = {sel_bank, act_cnt[IDX_W-1:0]};
    mem_wdata        = {tag_q, trk_q};
    mem_raddr        = {sel_bank, iss[IDX_W-1:0]};

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          trk_q_next  = s_tdata[15:0];
          tag_q_next  = s_tdata[31:16];
          head_q_next = s_tdata[47:32];
        end
      end
      ST_ADD: begin
        res_granted_next = 1'b0;
        res_trk_next     = '0;
        res_tag_next     = '0;
        res_dropped_next = 1'b0;
        if (policy == POL_FLOOK) begin
          if (pen_cnt == CNT_W'(QUEUE_DEPTH)) begin
            res_dropped_next = 1'b1;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = {!sel_bank, pen_cnt[IDX_W-1:0]};
            pen_cnt_next = pen_cnt + CNT_W'(1);
          end
        end else begin
          if (act_cnt == CNT_W'(QUEUE_DEPTH)) begin
            res_dropped_next = 1'b1;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = {sel_bank, act_cnt[IDX_W-1:0]};
            act_cnt_next = act_cnt + CNT_W'(1);
          end
        end
      end
      ST_SEL: begin
        res_granted_next = 1'b0;
        res_dropped_next = 1'b0;
        res_trk_next     = '0;
        res_tag_next     = '0;
        // Frozen look: an empty active queue takes over the pending bank.
        if (do_swap) begin
          sel_bank_next = !sel_bank;
          act_cnt_next  = pen_cnt;
          pen_cnt_next  = '0;
        end
        iss_next       = '0;
        found_next     = 1'b0;
        best_d_next    = '0;
        best_idx_next  = '0;
        pass2_next     = 1'b0;
        scan_head_next = head_q;
        scan_len_next  = eff_cnt;
        case (policy)
          POL_SSTF: begin
            mode_next = SM_ABS;
          end
          POL_LOOK, POL_FLOOK: begin
            mode_next = sweep_dir ? SM_UP : SM_DOWN;
          end
          POL_CLOOK: begin
            mode_next = SM_UP;
          end
          default: begin
            mode_next     = SM_FIRST;
            scan_len_next = CNT_W'(1);
          end
        endcase
      end
      ST_SCAN: begin
        if (iss != scan_len) begin
          iss_next     = iss + CNT_W'(1);
          cmp_vld_next = 1'b1;
          cmp_idx_next = iss[IDX_W-1:0];
        end
        if (cmp_vld && cmp_rsp.take) begin
          found_next    = 1'b1;
          best_d_next   = cmp_rsp.span;
          best_idx_next = cmp_idx;
          best_trk_next = mem_rdata[TrackW-1:0];
          best_tag_next = mem_rdata[EntryW-1:TrackW];
        end
        if (scan_done) begin
          if (retry) begin
            iss_next   = '0;
            pass2_next = 1'b1;
            if (is_look) begin
              sweep_dir_next = !sweep_dir;
              mode_next      = sweep_dir ? SM_DOWN : SM_UP;
            end else begin
              // Circular look wraps to the lowest track.
              mode_next      = SM_UP;
              scan_head_next = '0;
            end
          end else begin
            res_granted_next = 1'b1;
            res_trk_next     = best_trk;
            res_tag_next     = best_tag;
            iss_next         = CNT_W'(best_idx) + CNT_W'(1);
          end
        end
      end
      ST_SHIFT: begin
        // Close the gap: each entry above the taken one moves down a slot.
        if (iss != act_cnt) begin
          iss_next     = iss + CNT_W'(1);
          cmp_vld_next = 1'b1;
          cmp_idx_next = iss[IDX_W-1:0];
        end
        if (cmp_vld) begin
          mem_we    = 1'b1;
          mem_waddr = {sel_bank, cmp_idx - IDX_W'(1)};
          mem_wdata = mem_rdata;
        end
        if (shift_done) begin
          act_cnt_next = act_cnt - CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_vld_next  = 1'b1;
          out_data_next = {7'd0, sweep_dir, res_tag, res_trk};
          out_user_next = {res_dropped, res_granted};
        end
      end
      default: begin
        cmp_vld_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      policy    <= POL_FIFO;
      sel_bank  <= 1'b0;
      act_cnt   <= '0;
      pen_cnt   <= '0;
      sweep_dir <= 1'b1;
      iss       <= '0;
      scan_len  <= '0;
      cmp_vld   <= 1'b0;
      pass2     <= 1'b0;
      found     <= 1'b0;
      mode      <= SM_FIRST;
      out_vld   <= 1'b0;
    end else begin
      state     <= state_next;
      policy    <= policy_next;
      sel_bank  <= sel_bank_next;
      act_cnt   <= act_cnt_next;
      pen_cnt   <= pen_cnt_next;
      sweep_dir <= sweep_dir_next;
      iss       <= iss_next;
      scan_len  <= scan_len_next;
      cmp_vld   <= cmp_vld_next;
      pass2     <= pass2_next;
      found     <= found_next;
      mode      <= mode_next;
      out_vld   <= out_vld_next;
    end
  end

  always_ff @(posedge clk) begin
    trk_q       <= trk_q_next;
    tag_q       <= tag_q_next;
    head_q      <= head_q_next;
    cmp_idx     <= cmp_idx_next;
    scan_head   <= scan_head_next;
    best_d      <= best_d_next;
    best_idx    <= best_idx_next;
    best_trk    <= best_trk_next;
    best_tag    <= best_tag_next;
    res_granted <= res_granted_next;
    res_dropped <= res_dropped_next;
    res_trk     <= res_trk_next;
    res_tag     <= res_tag_next;
    out_data    <= out_data_next;
    out_user    <= out_user_next;
  end

endmodule

>>> hw/rtl/drs_checker.sv
module drs_checker
  import drs_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [MDataW-1:0] m_tdata,
  input logic [1:0]        m_tuser
);

  // The block works on one beat at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while previous beat still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result beat changed");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result both granted and dropped");

  a_empty_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
    else $error("ungranted result carries a request");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind disk_request_scheduler_unit drs_checker u_drs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
